[src/pwm_temperature_sensor_decoder_defines.svh]
// ----------------------------------------------------------------------------
// PWM temperature sensor decoder assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PWM_TEMPERATURE_SENSOR_DECODER_DEFINES_SVH
`define PWM_TEMPERATURE_SENSOR_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PWMTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PWMTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pwmtd_pkg.sv]
// ----------------------------------------------------------------------------
// pwmtd_pkg
// Types and constants shared by the PWM temperature sensor decoder.
// ----------------------------------------------------------------------------
package pwmtd_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CAP_W          = 16;
  localparam int TEMP_W         = 12;
  localparam int CFG_ADDR_W     = 1;
  localparam int SLOPE_W        = 13;
  localparam int OUT_DATA_W     = 16;

  localparam logic [SLOPE_W-1:0] SLOPE_TENTHS = SLOPE_W'(7200);
  localparam int                 BASE_TENTHS  = 4550;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOWER = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER = CFG_ADDR_W'(1);

  localparam logic signed [TEMP_W-1:0] LOWER_RESET = -TEMP_W'(505);
  localparam logic signed [TEMP_W-1:0] UPPER_RESET = TEMP_W'(1255);

  typedef struct packed {
    logic rise_wr;
    logic fall_ld;
    logic mul_go;
    logic div_step;
    logic finish;
  } pwmtd_cmd_t;

  typedef struct packed {
    logic out_free;
  } pwmtd_sts_t;

endpackage

[src/pwmtd_ctrl.sv]
// ----------------------------------------------------------------------------
// pwmtd_ctrl
// Sequencer for edge handling, multiply and bit-serial divide.
// ----------------------------------------------------------------------------
module pwmtd_ctrl import pwmtd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  output logic       in_tready,
  input  pwmtd_sts_t sts,
  output pwmtd_cmd_t cmd
);

  localparam int NW    = TIMER_BITS + SLOPE_W;
  localparam int CNT_W = $clog2(NW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.rise_wr = accept && in_tuser;
        cmd.fall_ld = accept && !in_tuser;
        if (accept && !in_tuser) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/pwmtd_dp.sv]
// ----------------------------------------------------------------------------
// pwmtd_dp
// Edge time registers, constant multiply, restoring divider, limit check
// and the output register.
// ----------------------------------------------------------------------------
module pwmtd_dp import pwmtd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CAP_W-1:0]      in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TEMP_W-1:0]     cfg_wdata,
  input  pwmtd_cmd_t            cmd,
  output pwmtd_sts_t            sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int NW = TIMER_BITS + SLOPE_W;
  localparam int RW = NW + 2;

  logic [TIMER_BITS-1:0]    t;
  logic [TIMER_BITS-1:0]    rise_r, rise_nxt;
  logic [TIMER_BITS-1:0]    fall_r, fall_nxt;
  logic [TIMER_BITS-1:0]    high_r, high_nxt;
  logic [TIMER_BITS-1:0]    low_r, low_nxt;
  logic [NW-1:0]            num_r, num_nxt;
  logic [TIMER_BITS-1:0]    rem_r, rem_nxt;
  logic [TIMER_BITS:0]      trial;
  logic                     ge;
  logic signed [TEMP_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [TEMP_W-1:0] held_r, held_nxt;
  logic signed [RW-1:0]     r;
  logic                     invalid, upd;
  logic                     ovalid_r, ovalid_nxt;
  logic [OUT_DATA_W-1:0]    odata_r, odata_nxt;

  assign t     = TIMER_BITS'(in_tdata);
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, low_r};

  assign invalid = (low_r == '0);
  assign r       = RW'(signed'(BASE_TENTHS)) - signed'({2'b00, num_r});
  assign upd     = !invalid && (r > RW'(lo_r)) && (r < RW'(hi_r));

  always_comb begin
    rise_nxt = rise_r;
    fall_nxt = fall_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    held_nxt = held_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    if (cmd.rise_wr) begin
      rise_nxt = t;
    end
    if (cmd.fall_ld) begin
      high_nxt = t - rise_r;
      low_nxt  = rise_r - fall_r;
      fall_nxt = t;
    end
    if (cmd.mul_go) begin
      num_nxt = NW'(high_r * SLOPE_TENTHS);
      rem_nxt = '0;
    end
    if (cmd.div_step) begin
      num_nxt = {num_r[NW-2:0], ge};
      rem_nxt = ge ? TIMER_BITS'(trial - {1'b0, low_r}) : trial[TIMER_BITS-1:0];
    end
    if (cmd.finish) begin
      if (upd) begin
        held_nxt = r[TEMP_W-1:0];
      end
      ovalid_nxt = 1'b1;
      odata_nxt  = {2'b00, invalid, upd, (upd ? r[TEMP_W-1:0] : held_r)};
    end
    if (cfg_we) begin
      case (cfg_addr)
        CFG_LOWER: lo_nxt = cfg_wdata;
        CFG_UPPER: hi_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r   <= '0;
      fall_r   <= '0;
      held_r   <= '0;
      lo_r     <= LOWER_RESET;
      hi_r     <= UPPER_RESET;
      ovalid_r <= 1'b0;
    end else begin
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      held_r   <= held_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r  <= high_nxt;
    low_r   <= low_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    odata_r <= odata_nxt;
  end

  assign sts.out_free = !ovalid_r || out_tready;
  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;

endmodule

[src/pwm_temperature_sensor_decoder.sv]
// ----------------------------------------------------------------------------
// pwm_temperature_sensor_decoder
// Decodes duty-cycle sensor edges into a held temperature in tenths of a
// degree Fahrenheit.
//
//   Channel  Dir  Handshake              Contents
//   in_      in   in_tvalid/in_tready    tdata capture_time, tuser pin_level
//   out_     out  out_tvalid/out_tready  held_temperature, updated, invalid
//   cfg_     in   cfg_we                 limit register writes
//
// A rising-edge transaction only records its capture time. A falling-edge
// transaction runs the multiply, then the one-bit-per-cycle divider.
// Reset clears the edge times and the held reading and restores both limits.
// A result waits in the output register; new edges are taken meanwhile.
// ----------------------------------------------------------------------------
module pwm_temperature_sensor_decoder import pwmtd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CAP_W-1:0]      in_tdata,   // [15:0] capture_time
  input  logic                  in_tuser,   // [0] pin_level
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] held_temperature,
                                            // [12] updated, [13] divide_invalid
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TEMP_W-1:0]     cfg_wdata
);

  pwmtd_cmd_t cmd;
  pwmtd_sts_t sts;

  pwmtd_ctrl #(.TIMER_BITS(TIMER_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwmtd_dp #(.TIMER_BITS(TIMER_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[src/pwmtd_checker.sv]
// ----------------------------------------------------------------------------
// pwmtd_checker
// Port-level assertions for the PWM temperature sensor decoder.
// ----------------------------------------------------------------------------
`include "pwm_temperature_sensor_decoder_defines.svh"

module pwmtd_checker import pwmtd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `PWMTD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PWMTD_ASSERT_NOW(a_flag_excl, out_tvalid, !(out_tdata[TEMP_W] && out_tdata[TEMP_W+1]), "updated with invalid divide")
  `PWMTD_ASSERT_NEXT(a_no_fast_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result right after a transaction")

endmodule

bind pwm_temperature_sensor_decoder pwmtd_checker u_pwmtd_checker (.*);
